@@ design/bsc_pkg.sv @@
// Shared widths, constants and register codes for the barometric compensation core.
package bsc_pkg;

    localparam int RAW_W   = 24;   // raw conversion words
    localparam int CAL_W   = 16;   // calibration words
    localparam int IDX_W   = 3;    // register index
    localparam int TEMP_W  = 19;   // compensated temperature, 0.01 C
    localparam int PRES_W  = 32;   // compensated pressure, 0.01 mbar
    localparam int DT_W    = 25;   // dT, signed
    localparam int SENS_W  = 40;   // final SENS, signed
    localparam int OFF_W   = 40;   // final OFF, signed
    localparam int PROD_W  = 64;   // D1 * SENS, signed
    localparam int LATENCY = 10;   // accept to result strobe, in cycles

    // 20.00 C and 20.00 C - (-15.00 C), as offsets on the dT*C6 term
    localparam logic signed [19:0] TEMP_BASE = 20'sd2000;
    localparam logic signed [19:0] COLD_BASE = 20'sd3500;

    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 19'sd262143;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -19'sd262144;

    typedef enum logic [IDX_W-1:0] {
        REG_C1 = 3'd0,
        REG_C2 = 3'd1,
        REG_C3 = 3'd2,
        REG_C4 = 3'd3,
        REG_C5 = 3'd4,
        REG_C6 = 3'd5
    } cal_index_t;

endpackage

@@ design/baro_sensor_compensation_core.sv @@
// Top level of the barometric pressure/temperature compensation pipeline.
//
// Second-order compensation of one raw pressure word (D1) and one raw temperature
// word (D2) into temperature in 0.01 C and pressure in 0.01 mbar, using the six
// calibration words C1..C6. An item transfers on a rising edge with start high;
// busy is always low, so a new pair can be taken every clock. Each item produces
// exactly one result, shown for one cycle with done high, once it has passed every
// stage; the pipeline never stalls and the receiver cannot hold
// results off, so it must take them when done is high. The pipeline is split into
// stages: dT, the four first-order products, the first-order terms,
// the two squares, the correction terms, the corrected TEMP/OFF/SENS, two stages
// for the split D1*SENS multiply, the final subtract, and the output register.
// Calibration words are written through cfg_we/cfg_index/cfg_wdata (index 0..5
// for C1..C6, other indexes ignored); write them only while no item is in flight.
// All shifts round toward minus infinity; outputs saturate to their port ranges.
module baro_sensor_compensation_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic        [bsc_pkg::RAW_W-1:0]       raw_pressure,
    input  logic        [bsc_pkg::RAW_W-1:0]       raw_temperature,
    output logic                                   done,
    output logic signed [bsc_pkg::TEMP_W-1:0]      temperature_centi,
    output logic signed [bsc_pkg::PRES_W-1:0]      pressure_centi_mbar,
    input  logic                                   cfg_we,
    input  logic        [bsc_pkg::IDX_W-1:0]       cfg_index,
    input  logic        [bsc_pkg::CAL_W-1:0]       cfg_wdata
);
    import bsc_pkg::*;

    // calibration words
    logic [CAL_W-1:0] c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;

    logic                 accept;
    logic [LATENCY-1:0]   valid_next, valid_reg;

    // stage 1: dT
    logic        [RAW_W-1:0]  d1_s1_reg;
    logic signed [DT_W-1:0]   dt_s1_next, dt_s1_reg;

    // stage 2: first-order products
    logic        [RAW_W-1:0]  d1_s2_reg;
    logic signed [41:0]       mt_s2_next, mt_s2_reg;
    logic signed [41:0]       mo_s2_next, mo_s2_reg;
    logic signed [41:0]       ms_s2_next, ms_s2_reg;
    logic signed [49:0]       mdd_s2_next, mdd_s2_reg;

    // stage 3: first-order TEMP, OFF, SENS and range flags
    logic        [RAW_W-1:0]  d1_s3_reg;
    logic signed [18:0]       td_s3_next, td_s3_reg;
    logic signed [19:0]       temp1_s3_next, temp1_s3_reg;
    logic signed [19:0]       tp_s3_next, tp_s3_reg;
    logic signed [36:0]       off1_s3_next, off1_s3_reg;
    logic signed [35:0]       sens1_s3_next, sens1_s3_reg;
    logic        [17:0]       t2_s3_next, t2_s3_reg;
    logic                     low_s3_next, low_s3_reg;
    logic                     cold_s3_next, cold_s3_reg;

    // stage 4: squares
    logic        [RAW_W-1:0]  d1_s4_reg;
    logic signed [37:0]       sq_full;
    logic signed [39:0]       sq2_full;
    logic        [34:0]       sq_s4_next, sq_s4_reg;
    logic        [34:0]       sq2_s4_next, sq2_s4_reg;
    logic signed [19:0]       temp1_s4_reg;
    logic signed [36:0]       off1_s4_reg;
    logic signed [35:0]       sens1_s4_reg;
    logic        [17:0]       t2_s4_reg;
    logic                     low_s4_reg, cold_s4_reg;

    // stage 5: second-order corrections
    logic        [RAW_W-1:0]  d1_s5_reg;
    logic        [38:0]       sq_x5, sq2_x7, sq2_x11;
    logic        [38:0]       off2_s5_next, off2_s5_reg;
    logic        [38:0]       sens2_s5_next, sens2_s5_reg;
    logic signed [19:0]       temp1_s5_reg;
    logic signed [36:0]       off1_s5_reg;
    logic signed [35:0]       sens1_s5_reg;
    logic        [17:0]       t2_s5_reg;
    logic                     low_s5_reg;

    // stage 6: corrected TEMP, OFF, SENS
    logic        [RAW_W-1:0]  d1_s6_reg;
    logic signed [19:0]       temp_s6_next, temp_s6_reg;
    logic signed [OFF_W-1:0]  off_s6_next, off_s6_reg;
    logic signed [SENS_W-1:0] sens_s6_next, sens_s6_reg;

    // stages 7, 8: multiply in bsc_split_mul, TEMP and OFF ride alongside
    logic signed [19:0]       temp_s7_reg, temp_s8_reg;
    logic signed [OFF_W-1:0]  off_s7_reg, off_s8_reg;
    logic signed [PROD_W-1:0] prod_s8;

    // stage 9: (D1*SENS >> 21) - OFF
    logic signed [43:0]       q_s9_next, q_s9_reg;
    logic signed [19:0]       temp_s9_reg;

    // stage 10: result register
    logic signed [28:0]       p_shift;
    logic signed [TEMP_W-1:0] temp_out_next, temp_out_reg;
    logic signed [PRES_W-1:0] pres_out_next, pres_out_reg;

    // ------------------------------------------------------------------
    // Transfer control: the pipeline always advances, so nothing blocks.
    // ------------------------------------------------------------------
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign valid_next = {valid_reg[LATENCY-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Calibration register file
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
            c5_reg <= '0;
            c6_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cal_index_t'(cfg_index))
                REG_C1:  c1_reg <= cfg_wdata;
                REG_C2:  c2_reg <= cfg_wdata;
                REG_C3:  c3_reg <= cfg_wdata;
                REG_C4:  c4_reg <= cfg_wdata;
                REG_C5:  c5_reg <= cfg_wdata;
                REG_C6:  c6_reg <= cfg_wdata;
                default: ;  // unused indexes are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath. Payload registers load every cycle; valid_reg says which
    // stages hold a live item.
    // ------------------------------------------------------------------

    // stage 1: dT = D2 - C5*256
    assign dt_s1_next = $signed({1'b0, raw_temperature}) - $signed({1'b0, c5_reg, 8'd0});

    always_ff @(posedge clk)
    begin
        d1_s1_reg <= raw_pressure;
        dt_s1_reg <= dt_s1_next;
    end

    // stage 2: dT*C6, C4*dT, C3*dT, dT*dT
    always_comb
    begin
        mt_s2_next  = dt_s1_reg * $signed({1'b0, c6_reg});
        mo_s2_next  = dt_s1_reg * $signed({1'b0, c4_reg});
        ms_s2_next  = dt_s1_reg * $signed({1'b0, c3_reg});
        mdd_s2_next = dt_s1_reg * dt_s1_reg;
    end

    always_ff @(posedge clk)
    begin
        d1_s2_reg  <= d1_s1_reg;
        mt_s2_reg  <= mt_s2_next;
        mo_s2_reg  <= mo_s2_next;
        ms_s2_reg  <= ms_s2_next;
        mdd_s2_reg <= mdd_s2_next;
    end

    // stage 3: td = TEMP - 2000, tp = TEMP + 1500
    always_comb
    begin
        td_s3_next    = mt_s2_reg[41:23];
        temp1_s3_next = $signed({td_s3_next[18], td_s3_next}) + TEMP_BASE;
        tp_s3_next    = $signed({td_s3_next[18], td_s3_next}) + COLD_BASE;
        off1_s3_next  = $signed({5'd0, c2_reg, 16'd0})
                      + $signed({{2{mo_s2_reg[41]}}, mo_s2_reg[41:7]});
        sens1_s3_next = $signed({5'd0, c1_reg, 15'd0})
                      + $signed({{2{ms_s2_reg[41]}}, ms_s2_reg[41:8]});
        t2_s3_next    = mdd_s2_reg[48:31];  // dT^2 >= 0
        low_s3_next   = td_s3_next[18];     // below 20.00 C
        cold_s3_next  = tp_s3_next[19];     // below -15.00 C
    end

    always_ff @(posedge clk)
    begin
        d1_s3_reg    <= d1_s2_reg;
        td_s3_reg    <= td_s3_next;
        temp1_s3_reg <= temp1_s3_next;
        tp_s3_reg    <= tp_s3_next;
        off1_s3_reg  <= off1_s3_next;
        sens1_s3_reg <= sens1_s3_next;
        t2_s3_reg    <= t2_s3_next;
        low_s3_reg   <= low_s3_next;
        cold_s3_reg  <= cold_s3_next;
    end

    // stage 4: (TEMP-2000)^2 and (TEMP+1500)^2, both below 2^35
    always_comb
    begin
        sq_full     = td_s3_reg * td_s3_reg;
        sq2_full    = tp_s3_reg * tp_s3_reg;
        sq_s4_next  = sq_full[34:0];
        sq2_s4_next = sq2_full[34:0];
    end

    always_ff @(posedge clk)
    begin
        d1_s4_reg    <= d1_s3_reg;
        sq_s4_reg    <= sq_s4_next;
        sq2_s4_reg   <= sq2_s4_next;
        temp1_s4_reg <= temp1_s3_reg;
        off1_s4_reg  <= off1_s3_reg;
        sens1_s4_reg <= sens1_s3_reg;
        t2_s4_reg    <= t2_s3_reg;
        low_s4_reg   <= low_s3_reg;
        cold_s4_reg  <= cold_s3_reg;
    end

    // stage 5: OFF2, SENS2 by shift-add; all terms non-negative
    always_comb
    begin
        sq_x5   = {2'd0, sq_s4_reg, 2'd0} + {4'd0, sq_s4_reg};
        sq2_x7  = {1'b0, sq2_s4_reg, 3'd0} - {4'd0, sq2_s4_reg};
        sq2_x11 = {1'b0, sq2_s4_reg, 3'd0} + {3'd0, sq2_s4_reg, 1'b0} + {4'd0, sq2_s4_reg};

        off2_s5_next  = '0;
        sens2_s5_next = '0;
        if (low_s4_reg)
        begin
            off2_s5_next  = sq_x5 >> 1;
            sens2_s5_next = sq_x5 >> 2;
            if (cold_s4_reg)
            begin
                off2_s5_next  = off2_s5_next + sq2_x7;
                sens2_s5_next = sens2_s5_next + (sq2_x11 >> 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        d1_s5_reg    <= d1_s4_reg;
        off2_s5_reg  <= off2_s5_next;
        sens2_s5_reg <= sens2_s5_next;
        temp1_s5_reg <= temp1_s4_reg;
        off1_s5_reg  <= off1_s4_reg;
        sens1_s5_reg <= sens1_s4_reg;
        t2_s5_reg    <= t2_s4_reg;
        low_s5_reg   <= low_s4_reg;
    end

    // stage 6: apply corrections
    always_comb
    begin
        temp_s6_next = temp1_s5_reg - (low_s5_reg ? $signed({2'd0, t2_s5_reg}) : 20'sd0);
        off_s6_next  = $signed({{3{off1_s5_reg[36]}}, off1_s5_reg})
                     - $signed({1'b0, off2_s5_reg});
        sens_s6_next = $signed({{4{sens1_s5_reg[35]}}, sens1_s5_reg})
                     - $signed({1'b0, sens2_s5_reg});
    end

    always_ff @(posedge clk)
    begin
        d1_s6_reg   <= d1_s5_reg;
        temp_s6_reg <= temp_s6_next;
        off_s6_reg  <= off_s6_next;
        sens_s6_reg <= sens_s6_next;
    end

    // stages 7 and 8: D1 * SENS
    bsc_split_mul u_mul (
        .clk  (clk),
        .a    (d1_s6_reg),
        .b    (sens_s6_reg),
        .prod (prod_s8)
    );

    always_ff @(posedge clk)
    begin
        temp_s7_reg <= temp_s6_reg;
        off_s7_reg  <= off_s6_reg;
        temp_s8_reg <= temp_s7_reg;
        off_s8_reg  <= off_s7_reg;
    end

    // stage 9: floor shift by 21, subtract OFF
    assign q_s9_next = $signed({prod_s8[PROD_W-1], prod_s8[PROD_W-1:21]})
                     - $signed({{4{off_s8_reg[OFF_W-1]}}, off_s8_reg});

    always_ff @(posedge clk)
    begin
        q_s9_reg    <= q_s9_next;
        temp_s9_reg <= temp_s8_reg;
    end

    // stage 10: floor shift by 15 and saturate. The shifted pressure is
    // 29 bits and always fits the 32-bit port, so sign extension is the clamp.
    always_comb
    begin
        p_shift       = q_s9_reg[43:15];
        pres_out_next = $signed({{(PRES_W-29){p_shift[28]}}, p_shift});
        if (temp_s9_reg > $signed({TEMP_MAX[TEMP_W-1], TEMP_MAX}))
        begin
            temp_out_next = TEMP_MAX;
        end
        else if (temp_s9_reg < $signed({TEMP_MIN[TEMP_W-1], TEMP_MIN}))
        begin
            temp_out_next = TEMP_MIN;
        end
        else
        begin
            temp_out_next = temp_s9_reg[TEMP_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        temp_out_reg <= temp_out_next;
        pres_out_reg <= pres_out_next;
    end

    assign done                = valid_reg[LATENCY-1];
    assign temperature_centi   = temp_out_reg;
    assign pressure_centi_mbar = pres_out_reg;

`ifndef SYNTH
    // every transfer yields its strobe after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("result strobe missing after transfer");

    // no strobe without a matching earlier transfer
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result strobe without transfer");

    // the low-temperature flag agrees with the first-order TEMP
    a_low_flag: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[2] |-> (low_s3_reg == (temp1_s3_reg < TEMP_BASE)))
        else $error("low-temperature flag disagrees with TEMP");

    // the very-cold branch lies inside the low-temperature branch
    a_cold_in_low: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[2] && cold_s3_reg |-> low_s3_reg)
        else $error("cold flag set outside low range");
`endif

endmodule

@@ design/bsc_split_mul.sv @@
// Two-stage D1 x SENS multiplier built from two narrow partial products.
module bsc_split_mul (
    input  logic                                 clk,
    input  logic        [bsc_pkg::RAW_W-1:0]     a,
    input  logic signed [bsc_pkg::SENS_W-1:0]    b,
    output logic signed [bsc_pkg::PROD_W-1:0]    prod
);
    import bsc_pkg::*;

    localparam int LO_W = SENS_W / 2;
    localparam int HI_W = SENS_W - LO_W;

    logic        [RAW_W+LO_W-1:0]   plo_next, plo_reg;
    logic signed [RAW_W+HI_W:0]     phi_next, phi_reg;
    logic signed [RAW_W+SENS_W:0]   sum;
    logic signed [PROD_W-1:0]       prod_next, prod_reg;

    // low half of b is unsigned, high half carries the sign
    always_comb
    begin
        plo_next = a * b[LO_W-1:0];
        phi_next = $signed({1'b0, a}) * $signed(b[SENS_W-1:LO_W]);
    end

    always_ff @(posedge clk)
    begin
        plo_reg <= plo_next;
        phi_reg <= phi_next;
    end

    always_comb
    begin
        sum       = $signed({phi_reg, {LO_W{1'b0}}})
                  + $signed({{(HI_W+1){1'b0}}, plo_reg});
        prod_next = sum[PROD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule
